### rtl/qlt_pkg.sv
// Shared types and constants of the query language tokenizer.
// Token kind codes, lexer modes and the result list carried between modules.
`default_nettype none

package qlt_pkg;

	localparam int NRes = 8;
	localparam int CntW = $clog2(NRes + 1);

	localparam logic [4:0] TK_END    = 5'd0;
	localparam logic [4:0] TK_SELECT = 5'd1;
	localparam logic [4:0] TK_FROM   = 5'd2;
	localparam logic [4:0] TK_WHERE  = 5'd3;
	localparam logic [4:0] TK_NOT    = 5'd4;
	localparam logic [4:0] TK_AND    = 5'd5;
	localparam logic [4:0] TK_OR     = 5'd6;
	localparam logic [4:0] TK_NULL   = 5'd7;
	localparam logic [4:0] TK_BOOL   = 5'd8;
	localparam logic [4:0] TK_LIKE   = 5'd9;
	localparam logic [4:0] TK_ISA    = 5'd10;
	localparam logic [4:0] TK_IDENT  = 5'd11;
	localparam logic [4:0] TK_INT    = 5'd12;
	localparam logic [4:0] TK_REAL   = 5'd13;
	localparam logic [4:0] TK_STRING = 5'd14;
	localparam logic [4:0] TK_EQ     = 5'd15;
	localparam logic [4:0] TK_NE     = 5'd16;
	localparam logic [4:0] TK_LT     = 5'd17;
	localparam logic [4:0] TK_LE     = 5'd18;
	localparam logic [4:0] TK_GT     = 5'd19;
	localparam logic [4:0] TK_GE     = 5'd20;
	localparam logic [4:0] TK_STAR   = 5'd21;
	localparam logic [4:0] TK_LPAREN = 5'd22;
	localparam logic [4:0] TK_RPAREN = 5'd23;
	localparam logic [4:0] TK_COMMA  = 5'd24;
	localparam logic [4:0] TK_DOT    = 5'd25;
	localparam logic [4:0] TK_COLON  = 5'd26;
	localparam logic [4:0] TK_ERROR  = 5'd27;

	localparam logic [63:0] INT_MAX_C = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ACC_LIM   = 64'd922337203685477580;

	typedef enum logic [3:0] {
		M_IDLE, M_WORD, M_IDENT, M_KWSKIP, M_STRING, M_OPHELD, M_SIGN,
		M_SIGNDOT, M_INT, M_FRAC, M_EXPE, M_EXPS, M_EXPD, M_ERROR
	} mode_t;

	typedef struct packed {
		logic [4:0]         token_kind;
		logic [7:0]         text_char;
		logic               has_char;
		logic               last;
		logic signed [63:0] integer_value;
		logic               boolean_value;
	} token_t;

	typedef struct packed {
		token_t [NRes-1:0] item;
		logic [CntW-1:0]   count;
	} rlist_t;

endpackage

`default_nettype wire

### rtl/qlt_in_if.sv
// Input channel of the tokenizer: one character or end-of-text mark per transfer.
// No dependencies.
`default_nettype none

interface qlt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       end_of_text;

	modport source(output valid, character, end_of_text, input ready);
	modport sink(input valid, character, end_of_text, output ready);
endinterface

`default_nettype wire

### rtl/qlt_out_if.sv
// Output channel of the tokenizer: one token item per transfer.
// No dependencies.
`default_nettype none

interface qlt_out_if;
	logic               valid;
	logic               ready;
	logic [4:0]         token_kind;
	logic [7:0]         text_char;
	logic               has_char;
	logic               last;
	logic signed [63:0] integer_value;
	logic               boolean_value;

	modport source(output valid, token_kind, text_char, has_char, last, integer_value,
		boolean_value, input ready);
	modport sink(input valid, token_kind, text_char, has_char, last, integer_value,
		boolean_value, output ready);
endinterface

`default_nettype wire

### rtl/query_language_tokenizer_top.sv
// The first token item of a character is offered in the cycle after its transfer.
// Throughput: one character per cycle while each yields at most one item and tx is ready;
// a character yielding more items holds the input until they are handed out, and input is
// taken again in the cycle of its final output transfer.
// Reset: arst_n clears the lexer mode and result counters; buffered text is undefined.
// Depends on qlt_pkg, qlt_in_if, qlt_out_if, qlt_core and qlt_outbuf.
`default_nettype none

module query_language_tokenizer_top import qlt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	qlt_in_if.sink    rx,
	qlt_out_if.source tx
);

	logic   take;
	logic   can_take;
	rlist_t list;

	assign rx.ready = can_take;
	assign take = rx.valid && can_take;

	qlt_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.character   (rx.character),
		.end_of_text (rx.end_of_text),
		.list        (list)
	);

	qlt_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.list     (list),
		.can_take (can_take),
		.tx       (tx)
	);

	a_eot_gives_token: assert property (@(posedge clk) disable iff (!arst_n)
		rx.valid && rx.ready && rx.end_of_text |=> tx.valid)
		else $error("end of text transfer produced no token");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!tx.valid |-> rx.ready)
		else $error("input stalled with empty result bank");

	a_no_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && !tx.has_char |-> tx.text_char == 8'h0)
		else $error("text_char set without has_char");

	a_int_only: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.token_kind != TK_INT |-> tx.integer_value == 64'sd0)
		else $error("integer value on non-integer token");

endmodule

`default_nettype wire

### rtl/qlt_core.sv
// Lexer state and single-pass next-state logic: one character in, a result list out.
// Depends on qlt_pkg.
`default_nettype none

module qlt_core import qlt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] character,
	input  wire logic       end_of_text,
	output rlist_t          list
);

	typedef struct packed {
		mode_t          mode;
		logic [5:0][7:0] wbuf;
		logic [2:0]     wlen;
		logic [7:0]     held;
		logic [7:0]     quote;
		logic           esc;
		logic [63:0]    acc;
		logic           neg;
		logic [1:0][7:0] la;
	} lex_state_t;

	typedef struct packed {
		mode_t       mode;
		logic [2:0]  wlen;
		logic [7:0]  held;
		logic [7:0]  quote;
		logic        esc;
		logic [63:0] acc;
		logic        neg;
	} ctl_t;

	typedef struct packed {
		logic [47:0] w;
		logic [2:0]  n;
		logic [4:0]  kind;
		logic        bv;
	} kw_t;

	ctl_t            ctl_q;
	logic [5:0][7:0] wbuf_q;
	logic [1:0][7:0] la_q;
	lex_state_t      cur;
	lex_state_t      nst;
	rlist_t          l;

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_word(logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == 8'h5F;
	endfunction

	function automatic logic [7:0] lower(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic kw_t kw_entry(int k);
		kw_t e;
		e.bv = 1'b0;
		unique case (k)
			0:       begin e.w = "select";          e.n = 3'd6; e.kind = TK_SELECT; end
			1:       begin e.w = {"from", 16'h0};   e.n = 3'd4; e.kind = TK_FROM; end
			2:       begin e.w = {"where", 8'h0};   e.n = 3'd5; e.kind = TK_WHERE; end
			3:       begin e.w = {"not", 24'h0};    e.n = 3'd3; e.kind = TK_NOT; end
			4:       begin e.w = {"and", 24'h0};    e.n = 3'd3; e.kind = TK_AND; end
			5:       begin e.w = {"or", 32'h0};     e.n = 3'd2; e.kind = TK_OR; end
			6:       begin e.w = {"null", 16'h0};   e.n = 3'd4; e.kind = TK_NULL; end
			7:       begin e.w = {"true", 16'h0};   e.n = 3'd4; e.kind = TK_BOOL; e.bv = 1'b1; end
			8:       begin e.w = {"false", 8'h0};   e.n = 3'd5; e.kind = TK_BOOL; end
			9:       begin e.w = {"like", 16'h0};   e.n = 3'd4; e.kind = TK_LIKE; end
			default: begin e.w = {"isa", 24'h0};    e.n = 3'd3; e.kind = TK_ISA; end
		endcase
		return e;
	endfunction

	function automatic void kw_find(input lex_state_t s, input logic [2:0] len,
		input logic [7:0] extra, input logic has_extra, output logic found, output kw_t hit);
		kw_t e;
		logic ok;
		found = 1'b0;
		hit = kw_entry(0);
		for (int k = 10; k >= 0; k--) begin
			e = kw_entry(k);
			ok = 1'b1;
			for (int i = 0; i < 6; i++) begin
				if (3'(i) < e.n && lower(s.wbuf[i]) != e.w[47-8*i -: 8])
					ok = 1'b0;
			end
			if (e.n > len)
				ok = 1'b0;
			else if (e.n < len) begin
				if (!is_digit(s.wbuf[e.n]))
					ok = 1'b0;
			end else if (has_extra && !is_digit(extra))
				ok = 1'b0;
			if (ok) begin
				found = 1'b1;
				hit = e;
			end
		end
	endfunction

	function automatic void emit(inout rlist_t r, input logic [4:0] k, input logic [7:0] ch,
		input logic has, input logic lst, input logic [63:0] iv, input logic bv);
		token_t t;
		t.token_kind = k;
		t.text_char = ch;
		t.has_char = has;
		t.last = lst;
		t.integer_value = iv;
		t.boolean_value = bv;
		if (r.count < CntW'(NRes)) begin
			r.item[r.count[$clog2(NRes)-1:0]] = t;
			r.count = r.count + 1'b1;
		end
	endfunction

	function automatic void emit_close(inout rlist_t r, input logic [4:0] k);
		emit(r, k, 8'h0, 1'b0, 1'b1, 64'd0, 1'b0);
	endfunction

	function automatic void emit_ch(inout rlist_t r, input logic [4:0] k, input logic [7:0] c);
		emit(r, k, c, 1'b1, 1'b0, 64'd0, 1'b0);
	endfunction

	function automatic void raise_error(inout lex_state_t s, inout rlist_t r);
		emit_close(r, TK_ERROR);
		s.mode = M_ERROR;
	endfunction

	function automatic void start(inout lex_state_t s, inout rlist_t r, input logic [7:0] c);
		priority if (c == 8'h20 || (c >= 8'd9 && c <= 8'd13)) begin
		end else if (c == "+" || c == "-") begin
			s.held = c;
			s.neg = (c == "-");
			s.acc = 64'd0;
			s.mode = M_SIGN;
		end else if (c == 8'h22 || c == 8'h27) begin
			s.quote = c;
			s.esc = 1'b0;
			s.mode = M_STRING;
		end else if (c == "=") emit_close(r, TK_EQ);
		else if (c == "<" || c == ">" || c == "!") begin
			s.held = c;
			s.mode = M_OPHELD;
		end else if (c == "*") emit_close(r, TK_STAR);
		else if (c == "(") emit_close(r, TK_LPAREN);
		else if (c == ")") emit_close(r, TK_RPAREN);
		else if (c == ",") emit_close(r, TK_COMMA);
		else if (c == ".") emit_close(r, TK_DOT);
		else if (c == ":") emit_close(r, TK_COLON);
		else if (is_alpha(c) || c == 8'h5F) begin
			s.wbuf[0] = c;
			s.wlen = 3'd1;
			s.mode = M_WORD;
		end else if (is_digit(c)) begin
			s.neg = 1'b0;
			s.acc = {56'd0, c - 8'h30};
			emit_ch(r, TK_INT, c);
			s.mode = M_INT;
		end else raise_error(s, r);
	endfunction

	function automatic void flush(inout lex_state_t s, inout rlist_t r);
		logic f;
		kw_t h;
		logic [63:0] v;
		unique case (s.mode)
			M_WORD: begin
				s.mode = M_IDLE;
				kw_find(s, s.wlen, 8'h0, 1'b0, f, h);
				if (f)
					emit(r, h.kind, 8'h0, 1'b0, 1'b1, 64'd0, h.bv);
				else begin
					for (int i = 0; i < 6; i++)
						if (3'(i) < s.wlen)
							emit_ch(r, TK_IDENT, s.wbuf[i]);
					emit_close(r, TK_IDENT);
				end
			end
			M_IDENT: begin
				emit_close(r, TK_IDENT);
				s.mode = M_IDLE;
			end
			M_KWSKIP: s.mode = M_IDLE;
			M_OPHELD: begin
				s.mode = M_IDLE;
				if (s.held == "<") emit_close(r, TK_LT);
				else if (s.held == ">") emit_close(r, TK_GT);
				else raise_error(s, r);
			end
			M_STRING, M_SIGN, M_SIGNDOT: raise_error(s, r);
			M_INT: begin
				if (s.neg) v = 64'd0 - s.acc;
				else v = (s.acc > INT_MAX_C) ? INT_MAX_C : s.acc;
				emit(r, TK_INT, 8'h0, 1'b0, 1'b1, v, 1'b0);
				s.mode = M_IDLE;
			end
			M_FRAC, M_EXPD: begin
				emit_close(r, TK_REAL);
				s.mode = M_IDLE;
			end
			M_EXPE: begin
				// relex the held 'e' as the start of a word
				emit_close(r, TK_REAL);
				s.wbuf[0] = s.la[0];
				s.wlen = 3'd1;
				s.mode = M_WORD;
			end
			M_EXPS: begin
				// relex 'e' as a one-letter identifier, then the sign
				emit_close(r, TK_REAL);
				emit_ch(r, TK_IDENT, s.la[0]);
				emit_close(r, TK_IDENT);
				s.held = s.la[1];
				s.neg = (s.la[1] == "-");
				s.acc = 64'd0;
				s.mode = M_SIGN;
			end
			default: ;
		endcase
	endfunction

	function automatic logic feed1(inout lex_state_t s, inout rlist_t r, input logic [7:0] c);
		logic ok;
		logic f;
		kw_t h;
		logic [7:0] d;
		logic [63:0] lim;
		ok = 1'b1;
		d = c - 8'h30;
		unique case (s.mode)
			M_ERROR: ;
			M_IDLE: start(s, r, c);
			M_WORD: begin
				if (!is_word(c)) ok = 1'b0;
				else if (s.wlen < 3'd6) begin
					s.wbuf[s.wlen] = c;
					s.wlen = s.wlen + 3'd1;
				end else begin
					kw_find(s, 3'd6, c, 1'b1, f, h);
					if (f) begin
						emit(r, h.kind, 8'h0, 1'b0, 1'b1, 64'd0, h.bv);
						s.mode = M_KWSKIP;
					end else begin
						for (int i = 0; i < 6; i++)
							emit_ch(r, TK_IDENT, s.wbuf[i]);
						emit_ch(r, TK_IDENT, c);
						s.mode = M_IDENT;
					end
				end
			end
			M_IDENT: begin
				if (!is_word(c)) ok = 1'b0;
				else emit_ch(r, TK_IDENT, c);
			end
			M_KWSKIP: ok = is_word(c);
			M_STRING: begin
				if (s.esc) begin
					s.esc = 1'b0;
					emit_ch(r, TK_STRING, (c == "n") ? 8'd10 : (c == "r") ? 8'd13 :
						(c == "f") ? 8'd12 : c);
				end else if (c == 8'h5C) s.esc = 1'b1;
				else if (c == s.quote) begin
					emit_close(r, TK_STRING);
					s.mode = M_IDLE;
				end else emit_ch(r, TK_STRING, c);
			end
			M_OPHELD: begin
				if (s.held == "<" && c == ">") begin
					emit_close(r, TK_NE);
					s.mode = M_IDLE;
				end else if (s.held == "<" && c == "=") begin
					emit_close(r, TK_LE);
					s.mode = M_IDLE;
				end else if (s.held == ">" && c == "=") begin
					emit_close(r, TK_GE);
					s.mode = M_IDLE;
				end else if (s.held == "!" && c == "=") begin
					emit_close(r, TK_NE);
					s.mode = M_IDLE;
				end else if (s.held == "!") raise_error(s, r);
				else ok = 1'b0;
			end
			M_SIGN: begin
				if (is_digit(c)) begin
					emit_ch(r, TK_INT, s.held);
					emit_ch(r, TK_INT, c);
					s.acc = {56'd0, d};
					s.mode = M_INT;
				end else if (c == ".") s.mode = M_SIGNDOT;
				else raise_error(s, r);
			end
			M_SIGNDOT: begin
				if (is_digit(c)) begin
					emit_ch(r, TK_REAL, s.held);
					emit_ch(r, TK_REAL, ".");
					emit_ch(r, TK_REAL, c);
					s.mode = M_FRAC;
				end else raise_error(s, r);
			end
			M_INT: begin
				if (is_digit(c)) begin
					// saturate at the magnitude of the most negative value
					lim = (d == 8'd9) ? ACC_LIM - 64'd1 : ACC_LIM;
					if (s.acc > lim) s.acc = MAG_LIMIT;
					else s.acc = (s.acc << 3) + (s.acc << 1) + {56'd0, d};
					emit_ch(r, TK_INT, c);
				end else if (c == ".") begin
					emit_ch(r, TK_REAL, c);
					s.mode = M_FRAC;
				end else ok = 1'b0;
			end
			M_FRAC: begin
				if (is_digit(c)) emit_ch(r, TK_REAL, c);
				else if (c == "e" || c == "E") begin
					s.la[0] = c;
					s.mode = M_EXPE;
				end else ok = 1'b0;
			end
			M_EXPE: begin
				if (is_digit(c)) begin
					emit_ch(r, TK_REAL, s.la[0]);
					emit_ch(r, TK_REAL, c);
					s.mode = M_EXPD;
				end else if (c == "+" || c == "-") begin
					s.la[1] = c;
					s.mode = M_EXPS;
				end else ok = 1'b0;
			end
			M_EXPS: begin
				if (is_digit(c)) begin
					emit_ch(r, TK_REAL, s.la[0]);
					emit_ch(r, TK_REAL, s.la[1]);
					emit_ch(r, TK_REAL, c);
					s.mode = M_EXPD;
				end else ok = 1'b0;
			end
			M_EXPD: begin
				if (is_digit(c)) emit_ch(r, TK_REAL, c);
				else ok = 1'b0;
			end
			default: begin
				s.mode = M_IDLE;
				start(s, r, c);
			end
		endcase
		return ok;
	endfunction

	always_comb begin
		cur.mode = ctl_q.mode;
		cur.wbuf = wbuf_q;
		cur.wlen = ctl_q.wlen;
		cur.held = ctl_q.held;
		cur.quote = ctl_q.quote;
		cur.esc = ctl_q.esc;
		cur.acc = ctl_q.acc;
		cur.neg = ctl_q.neg;
		cur.la = la_q;
	end

	always_comb begin
		nst = cur;
		l = '0;
		if (end_of_text || character == 8'h0) begin
			flush(nst, l);
			emit_close(l, TK_END);
			nst.mode = M_IDLE;
			nst.wlen = 3'd0;
			nst.held = 8'h0;
			nst.quote = 8'h0;
			nst.esc = 1'b0;
			nst.acc = 64'd0;
			nst.neg = 1'b0;
		end else if (!feed1(nst, l, character)) begin
			flush(nst, l);
			if (!feed1(nst, l, character)) begin
				flush(nst, l);
				void'(feed1(nst, l, character));
			end
		end
	end

	assign list = l;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '{mode: M_IDLE, default: '0};
		end else if (take) begin
			ctl_q.mode <= nst.mode;
			ctl_q.wlen <= nst.wlen;
			ctl_q.held <= nst.held;
			ctl_q.quote <= nst.quote;
			ctl_q.esc <= nst.esc;
			ctl_q.acc <= nst.acc;
			ctl_q.neg <= nst.neg;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			wbuf_q <= nst.wbuf;
			la_q <= nst.la;
		end
	end

endmodule

`default_nettype wire

### rtl/qlt_outbuf.sv
// Result register bank: holds the token items of one character and hands them out.
// Depends on qlt_pkg and qlt_out_if.
`default_nettype none

module qlt_outbuf import qlt_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   take,
	input  wire rlist_t list,
	output logic        can_take,
	qlt_out_if.source   tx
);

	token_t [NRes-1:0] res_q;
	logic [CntW-1:0]   cnt_q;
	logic [CntW-1:0]   idx_q;
	logic [CntW-1:0]   pend;
	token_t            head;

	assign pend = cnt_q - idx_q;
	assign tx.valid = (pend != '0);
	assign can_take = (pend == '0) || (pend == CntW'(1) && tx.ready);
	assign head = res_q[idx_q[$clog2(NRes)-1:0]];

	assign tx.token_kind = head.token_kind;
	assign tx.text_char = head.text_char;
	assign tx.has_char = head.has_char;
	assign tx.last = head.last;
	assign tx.integer_value = head.integer_value;
	assign tx.boolean_value = head.boolean_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (take) begin
			cnt_q <= list.count;
			idx_q <= '0;
		end else if (tx.valid && tx.ready) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			res_q <= list.item;
	end

endmodule

`default_nettype wire

### verif/tb_qlt_scoreboard.sv
// Scoreboard of the tokenizer testbench: software lexer and queue of expected tokens.
// Depends on qlt_pkg.
`timescale 1ns / 100ps

package tb_qlt_sb_pkg;
	import qlt_pkg::*;

	class token_scoreboard;
		mode_t       mode;
		logic [7:0]  word[6];
		int          word_len;
		logic [7:0]  held_op;
		logic [7:0]  quote;
		bit          esc;
		logic [63:0] mag;
		bit          neg;
		logic [7:0]  exp_hold[2];
		token_t      pending_tokens[$];
		int          mismatches;
		int          tokens_checked;
		int          chars_noted;

		function new();
			mismatches = 0;
			tokens_checked = 0;
			chars_noted = 0;
			clear_lexer();
		endfunction

		function void clear_lexer();
			mode = M_IDLE;
			word_len = 0;
			held_op = 0;
			quote = 0;
			esc = 0;
			mag = 0;
			neg = 0;
			foreach (word[i]) word[i] = 0;
			exp_hold[0] = 0;
			exp_hold[1] = 0;
		endfunction

		function void push(logic [4:0] kind, logic [7:0] ch, bit has, bit lst,
				logic [63:0] ival, bit bval);
			token_t t;
			t.token_kind = kind;
			t.text_char = ch;
			t.has_char = has;
			t.last = lst;
			t.integer_value = ival;
			t.boolean_value = bval;
			pending_tokens.push_back(t);
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit is_alpha(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		function bit is_word(logic [7:0] c);
			return is_alpha(c) || is_digit(c) || c == "_";
		endfunction

		function void fail_token();
			push(TK_ERROR, 0, 0, 1, 0, 0);
			mode = M_ERROR;
		endfunction

		function int match_keyword(int len, logic [7:0] extra, bit has_extra);
			string       names[11];
			string       w;
			logic [7:0]  c;
			bit          ok;
			int          n;
			names = '{"select", "from", "where", "not", "and", "or", "null", "true",
				"false", "like", "isa"};
			if (len > 6)
				len = 6;
			for (int k = 0; k < 11; k++) begin
				w = names[k];
				n = w.len();
				if (n > len)
					continue;
				ok = 1;
				for (int i = 0; i < n; i++) begin
					c = word[i];
					if (c >= "A" && c <= "Z")
						c = c + 8'd32;
					if (c != w[i])
						ok = 0;
				end
				if (!ok)
					continue;
				if (n < len) begin
					if (!is_digit(word[n]))
						continue;
				end else if (has_extra && !is_digit(extra))
					continue;
				return k;
			end
			return -1;
		endfunction

		function void keyword_token(int k);
			logic [4:0] kinds[11];
			kinds = '{TK_SELECT, TK_FROM, TK_WHERE, TK_NOT, TK_AND, TK_OR, TK_NULL,
				TK_BOOL, TK_BOOL, TK_LIKE, TK_ISA};
			push(kinds[k], 0, 0, 1, 0, k == 7);
		endfunction

		function void begin_token(logic [7:0] c);
			case (c)
				" ", 8'd9, 8'd10, 8'd11, 8'd12, 8'd13: ;
				"+", "-": begin
					held_op = c;
					neg = c == "-";
					mag = 0;
					mode = M_SIGN;
				end
				"\"", "'": begin
					quote = c;
					esc = 0;
					mode = M_STRING;
				end
				"=": push(TK_EQ, 0, 0, 1, 0, 0);
				"<", ">", "!": begin
					held_op = c;
					mode = M_OPHELD;
				end
				"*": push(TK_STAR, 0, 0, 1, 0, 0);
				"(": push(TK_LPAREN, 0, 0, 1, 0, 0);
				")": push(TK_RPAREN, 0, 0, 1, 0, 0);
				",": push(TK_COMMA, 0, 0, 1, 0, 0);
				".": push(TK_DOT, 0, 0, 1, 0, 0);
				":": push(TK_COLON, 0, 0, 1, 0, 0);
				default: begin
					if (is_alpha(c) || c == "_") begin
						word[0] = c;
						word_len = 1;
						mode = M_WORD;
					end else if (is_digit(c)) begin
						neg = 0;
						mag = c - "0";
						push(TK_INT, c, 1, 0, 0, 0);
						mode = M_INT;
					end else
						fail_token();
				end
			endcase
		endfunction

		function void close_token();
			logic [63:0] v;
			logic [7:0]  e0, e1;
			int          k;
			e0 = exp_hold[0];
			e1 = exp_hold[1];
			case (mode)
				M_WORD: begin
					mode = M_IDLE;
					k = match_keyword(word_len, 0, 0);
					if (k >= 0)
						keyword_token(k);
					else begin
						for (int i = 0; i < word_len && i < 6; i++)
							push(TK_IDENT, word[i], 1, 0, 0, 0);
						push(TK_IDENT, 0, 0, 1, 0, 0);
					end
				end
				M_IDENT: begin
					push(TK_IDENT, 0, 0, 1, 0, 0);
					mode = M_IDLE;
				end
				M_KWSKIP: mode = M_IDLE;
				M_OPHELD: begin
					mode = M_IDLE;
					if (held_op == "<")
						push(TK_LT, 0, 0, 1, 0, 0);
					else if (held_op == ">")
						push(TK_GT, 0, 0, 1, 0, 0);
					else
						fail_token();
				end
				M_STRING, M_SIGN, M_SIGNDOT: fail_token();
				M_INT: begin
					if (neg)
						v = 64'd0 - mag;
					else
						v = mag > INT_MAX_C ? INT_MAX_C : mag;
					push(TK_INT, 0, 0, 1, v, 0);
					mode = M_IDLE;
				end
				M_FRAC, M_EXPD: begin
					push(TK_REAL, 0, 0, 1, 0, 0);
					mode = M_IDLE;
				end
				M_EXPE: begin
					push(TK_REAL, 0, 0, 1, 0, 0);
					mode = M_IDLE;
					lex_char(e0);
				end
				M_EXPS: begin
					push(TK_REAL, 0, 0, 1, 0, 0);
					mode = M_IDLE;
					lex_char(e0);
					lex_char(e1);
				end
				default: ;
			endcase
		endfunction

		function void lex_char(logic [7:0] c);
			logic [63:0] d;
			logic [7:0]  x;
			int          k;
			case (mode)
				M_ERROR: return;
				M_IDLE: begin
					begin_token(c);
					return;
				end
				M_WORD: if (is_word(c)) begin
					if (word_len < 6) begin
						word[word_len] = c;
						word_len++;
						return;
					end
					k = match_keyword(6, c, 1);
					if (k >= 0) begin
						keyword_token(k);
						mode = M_KWSKIP;
						return;
					end
					for (int i = 0; i < 6; i++)
						push(TK_IDENT, word[i], 1, 0, 0, 0);
					push(TK_IDENT, c, 1, 0, 0, 0);
					mode = M_IDENT;
					return;
				end
				M_IDENT: if (is_word(c)) begin
					push(TK_IDENT, c, 1, 0, 0, 0);
					return;
				end
				M_KWSKIP: if (is_word(c))
					return;
				M_STRING: begin
					if (esc) begin
						x = c == "n" ? 8'd10 : c == "r" ? 8'd13 : c == "f" ? 8'd12 : c;
						esc = 0;
						push(TK_STRING, x, 1, 0, 0, 0);
					end else if (c == "\\")
						esc = 1;
					else if (c == quote) begin
						push(TK_STRING, 0, 0, 1, 0, 0);
						mode = M_IDLE;
					end else
						push(TK_STRING, c, 1, 0, 0, 0);
					return;
				end
				M_OPHELD: begin
					if (held_op == "<" && c == ">") begin
						push(TK_NE, 0, 0, 1, 0, 0);
						mode = M_IDLE;
						return;
					end
					if (held_op == "<" && c == "=") begin
						push(TK_LE, 0, 0, 1, 0, 0);
						mode = M_IDLE;
						return;
					end
					if (held_op == ">" && c == "=") begin
						push(TK_GE, 0, 0, 1, 0, 0);
						mode = M_IDLE;
						return;
					end
					if (held_op == "!" && c == "=") begin
						push(TK_NE, 0, 0, 1, 0, 0);
						mode = M_IDLE;
						return;
					end
					if (held_op == "!") begin
						fail_token();
						return;
					end
				end
				M_SIGN: begin
					if (is_digit(c)) begin
						push(TK_INT, held_op, 1, 0, 0, 0);
						push(TK_INT, c, 1, 0, 0, 0);
						mag = c - "0";
						mode = M_INT;
					end else if (c == ".")
						mode = M_SIGNDOT;
					else
						fail_token();
					return;
				end
				M_SIGNDOT: begin
					if (is_digit(c)) begin
						push(TK_REAL, held_op, 1, 0, 0, 0);
						push(TK_REAL, ".", 1, 0, 0, 0);
						push(TK_REAL, c, 1, 0, 0, 0);
						mode = M_FRAC;
					end else
						fail_token();
					return;
				end
				M_INT: begin
					if (is_digit(c)) begin
						d = c - "0";
						if (mag > (MAG_LIMIT - d) / 10)
							mag = MAG_LIMIT;
						else
							mag = mag * 10 + d;
						push(TK_INT, c, 1, 0, 0, 0);
						return;
					end
					if (c == ".") begin
						push(TK_REAL, c, 1, 0, 0, 0);
						mode = M_FRAC;
						return;
					end
				end
				M_FRAC: begin
					if (is_digit(c)) begin
						push(TK_REAL, c, 1, 0, 0, 0);
						return;
					end
					if (c == "e" || c == "E") begin
						exp_hold[0] = c;
						mode = M_EXPE;
						return;
					end
				end
				M_EXPE: begin
					if (is_digit(c)) begin
						push(TK_REAL, exp_hold[0], 1, 0, 0, 0);
						push(TK_REAL, c, 1, 0, 0, 0);
						mode = M_EXPD;
						return;
					end
					if (c == "+" || c == "-") begin
						exp_hold[1] = c;
						mode = M_EXPS;
						return;
					end
				end
				M_EXPS: if (is_digit(c)) begin
					push(TK_REAL, exp_hold[0], 1, 0, 0, 0);
					push(TK_REAL, exp_hold[1], 1, 0, 0, 0);
					push(TK_REAL, c, 1, 0, 0, 0);
					mode = M_EXPD;
					return;
				end
				M_EXPD: if (is_digit(c)) begin
					push(TK_REAL, c, 1, 0, 0, 0);
					return;
				end
				default: begin
					mode = M_IDLE;
					begin_token(c);
					return;
				end
			endcase
			close_token();
			lex_char(c);
		endfunction

		function void note_char(logic [7:0] c, bit eot);
			chars_noted++;
			if (eot || c == 0) begin
				close_token();
				push(TK_END, 0, 0, 1, 0, 0);
				clear_lexer();
			end else
				lex_char(c);
		endfunction

		function void check_token(token_t got);
			token_t want;
			tokens_checked++;
			if (pending_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token item %p", got);
				return;
			end
			want = pending_tokens.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("token mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass
endpackage

### verif/tb_query_language_tokenizer_top.sv
// Top of the tokenizer testbench: clock, reset, character driver and token monitor.
// Depends on qlt_pkg, qlt_in_if, qlt_out_if, tb_qlt_sb_pkg and query_language_tokenizer_top.
`timescale 1ns / 100ps

module tb_query_language_tokenizer_top;
	import qlt_pkg::*;
	import tb_qlt_sb_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	qlt_in_if  rx();
	qlt_out_if tx();

	query_language_tokenizer_top DUT(.clk(clk), .arst_n(arst_n), .rx(rx), .tx(tx));

	token_scoreboard scoreboard = new();
	int  cycle_count = 0;
	int  hold_off = 0;
	bit  calm = 0;
	int  chars_sent = 0;

	always #1 clk = ~clk;

	initial begin
		rx.valid = 0;
		rx.character = 0;
		rx.end_of_text = 0;
		tx.ready = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 200000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rx.valid && rx.ready)
			scoreboard.note_char(rx.character, rx.end_of_text);
		if (tx.valid && tx.ready)
			scoreboard.check_token({tx.token_kind, tx.text_char, tx.has_char, tx.last,
				tx.integer_value, tx.boolean_value});
	end

	always @(posedge clk) begin
		if (!arst_n)
			tx.ready <= 0;
		else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			tx.ready <= 0;
		end else
			tx.ready <= calm || $urandom_range(99) >= 20;
	end

	task automatic send_char(logic [7:0] c, bit eot);
		while (!calm && $urandom_range(99) < 20) begin
			rx.valid <= 0;
			@(posedge clk);
		end
		rx.valid <= 1;
		rx.character <= c;
		rx.end_of_text <= eot;
		@(posedge clk);
		while (!rx.ready)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], 1'b0);
	endtask

	function automatic string random_fragment();
		string pieces[] = '{"select", "FROM", "Where", "not", "and", "Or", "NULL",
			"true", "FaLsE", "like", "isa", "select1", "selects", "abcdefghij",
			"_x9", "fromage", "9223372036854775807", "-9223372036854775808",
			"99999999999999999999", "-42", "+7", "3.25", "1.5e10", "2.0E-3",
			"4.0e", "6.1e+x", "-.5", "'it\\'s'", "\"a\\nb\\rc\\fd\\q\"", "<>", "!=",
			"<=", ">=", "<", ">", "=", "*", "(", ")", ",", ".", ":", " ", "\t"};
		string s;
		int n;
		if ($urandom_range(9) == 0) begin
			s = "";
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++)
				s = {s, string'(8'($urandom_range(1, 255)))};
			return s;
		end
		return {pieces[$urandom_range(pieces.size() - 1)], " "};
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_text("SELECT a,b FROM tbl WHERE x<>1 AND y>=-2 OR z!=3.5e+2 ");
		send_char(8'h0, 1'b0);
		send_text("isa null NOT like 'q\\n' true false ; ");
		send_char(8'hFF, 1'b1);
		send_text("+ ! \"open");
		send_char(8'h80, 1'b1);
		calm = 1;
		fork
			hold_off = 300;
		join_none
		send_text("aaaaaaaaaaaa 123456 'bbbbbbbbbbbb' ");
		send_char(8'h0, 1'b1);
		while (chars_sent < 415) begin
			if (chars_sent > 200)
				calm = 0;
			send_text(random_fragment());
			if ($urandom_range(7) == 0)
				send_char(8'($urandom_range(255)), 1'b1);
		end
		send_char(8'h55, 1'b1);
		rx.valid <= 0;
		calm = 0;
		while (scoreboard.pending_tokens.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d characters; checked %0d token items across keywords, numbers,",
			chars_sent, scoreboard.tokens_checked);
		$display("strings, operators, errors and end-of-text marks.");
		if (scoreboard.mismatches == 0 && scoreboard.pending_tokens.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

### filelist.f
rtl/qlt_pkg.sv
rtl/qlt_in_if.sv
rtl/qlt_out_if.sv
rtl/qlt_core.sv
rtl/qlt_outbuf.sv
rtl/query_language_tokenizer_top.sv
verif/tb_qlt_scoreboard.sv
verif/tb_query_language_tokenizer_top.sv
